// ----- src/zcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Zero-crossing phase estimator package
// Request types, sequencer states and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package zcpe_pkg;

    // One input request: a time-stamped, mean-removed sample.
    typedef struct packed {
        logic signed [31:0] sample_time;
        logic signed [15:0] sample_value;
        logic               last_sample;
    } t_zcpe_in;

    // One result request: mean phase, crossing count and status.
    typedef struct packed {
        logic signed [31:0] mean_phase;
        logic [4:0]         crossing_count;
        logic               status;
    } t_zcpe_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_SUM,
        ST_END,
        ST_SAT
    } t_zcpe_state;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_LEN_ERR = 1'b1;

    localparam logic [5:0] SEEN_MAX  = 6'd63;
    localparam logic [4:0] ZC_MAX    = 5'd31;
    localparam int         DIV_STEPS = 48;

endpackage

// ----- src/zero_crossing_phase_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// Zero-crossing phase estimator
// Interpolates rising zero crossings in a sample block and averages the
// period-adjusted crossing times, using one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: a sample with no rising crossing is taken in the idle state; a
// crossing adds the multiply, load, divide, fix and accumulate states. The last
// sample adds the end state, plus a mean division (load, divide, saturate) when
// the block is valid and holds crossings, plus any wait for the output register.
// Throughput: one request at a time; a new sample waits while the divider works.
// Reset: synchronous, active low; clears the period register and block state.
module zero_crossing_phase_estimator_unit #(
    parameter int BLOCK_SAMPLES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [30:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  zcpe_pkg::t_zcpe_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output zcpe_pkg::t_zcpe_out  o_out_data
);
    import zcpe_pkg::*;

    // Sequencer state.
    t_zcpe_state r_state, n_state;

    // Configuration: spacing between successive crossings, unsigned Q15.16 ns.
    logic [30:0] r_period;

    // Block state carried between samples.
    logic signed [31:0] r_prev_time;
    logic signed [15:0] r_prev_value;
    logic               r_have_prev;
    logic [39:0]        r_phase_sum;
    logic [39:0]        r_period_offset;
    logic [4:0]         r_zc_count;
    logic [5:0]         r_seen;
    logic               r_last;

    // Operands of the crossing under work, captured when the sample arrives.
    logic signed [31:0] r_x1;
    logic signed [32:0] r_dx;
    logic [15:0]        r_ny1;
    logic [15:0]        r_den;
    logic signed [48:0] r_prod;
    logic [39:0]        r_zc_time;

    // Shared restoring divider: r_quo shifts the dividend out and the
    // quotient in; r_rem always stays below the divisor.
    logic [47:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_op_mean;

    // Output register.
    logic       r_out_valid;
    t_zcpe_out  r_out_data;

    // Handshake and sequencer controls.
    logic in_accept;
    logic out_free;
    logic out_load;
    logic is_crossing;
    logic len_ok;
    logic div_done;

    // Datapath helpers.
    logic [16:0]        div_trial;
    logic               div_ge;
    logic [16:0]        div_diff;
    logic signed [49:0] mul_full;
    logic [47:0]        prod_mag;
    logic [39:0]        sum_mag;
    logic [39:0]        quo_signed;
    logic [31:0]        sat_val;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign len_ok    = (r_seen == 6'(BLOCK_SAMPLES));
    assign div_done  = (r_cnt == 6'd0);

    // The block result is loaded into the output register in this cycle.
    assign out_load = out_free && ((r_state == ST_SAT) ||
                      ((r_state == ST_END) && !(len_ok && (r_zc_count != 5'd0))));

    // A rising crossing needs a stored negative sample followed by a
    // positive one, and the crossing counter must still have room.
    assign is_crossing = r_have_prev && (r_prev_value < 16'sd0) &&
                         (i_in_data.sample_value > 16'sd0) && (r_zc_count < ZC_MAX);

    // One divider step: bring down the next dividend bit and try a subtract.
    assign div_trial = {r_rem, r_quo[47]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});
    assign div_diff  = div_trial - {1'b0, r_dvs};

    // The numerator magnitude stays below 2^47, so 48 dividend bits suffice.
    assign mul_full = $signed({1'b0, r_ny1}) * r_dx;
    assign prod_mag = r_prod[48] ? 48'(-r_prod) : r_prod[47:0];
    assign sum_mag  = r_phase_sum[39] ? (40'd0 - r_phase_sum) : r_phase_sum;

    // Quotient truncates toward zero: the magnitude is divided, then negated.
    assign quo_signed = r_neg ? (40'd0 - r_quo[39:0]) : r_quo[39:0];

    // The mean magnitude is at most 2^39; clamp it into 32 signed bits.
    always_comb begin
        if (r_neg) begin
            if (r_quo > 48'h0000_8000_0000) begin
                sat_val = 32'h8000_0000;
            end else begin
                sat_val = 32'd0 - r_quo[31:0];
            end
        end else begin
            if (r_quo > 48'h0000_7FFF_FFFF) begin
                sat_val = 32'h7FFF_FFFF;
            end else begin
                sat_val = r_quo[31:0];
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (is_crossing) begin
                        n_state = ST_MUL;
                    end else if (i_in_data.last_sample) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_MUL:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = r_op_mean ? ST_SAT : ST_FIX;
                end
            end
            ST_FIX:  n_state = ST_SUM;
            ST_SUM:  n_state = r_last ? ST_END : ST_IDLE;
            ST_END: begin
                if (len_ok && (r_zc_count != 5'd0)) begin
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SAT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs: new samples are taken only while the sequencer idles.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
        o_out_data  = r_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 31'd0;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Block state, output register and control of the shared divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time     <= '0;
            r_prev_value    <= '0;
            r_have_prev     <= 1'b0;
            r_phase_sum     <= '0;
            r_period_offset <= '0;
            r_zc_count      <= '0;
            r_seen          <= '0;
            r_last          <= 1'b0;
            r_op_mean       <= 1'b0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (r_seen < SEEN_MAX) begin
                            r_seen <= r_seen + 6'd1;
                        end
                        r_prev_time  <= i_in_data.sample_time;
                        r_prev_value <= i_in_data.sample_value;
                        r_have_prev  <= 1'b1;
                        r_last       <= i_in_data.last_sample;
                        r_op_mean    <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    r_cnt <= 6'(DIV_STEPS - 1);
                end
                ST_DIV: begin
                    if (!div_done) begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_SUM: begin
                    // Subtract the crossing number times the period, then
                    // advance that offset for the next crossing.
                    r_phase_sum     <= r_phase_sum + r_zc_time - r_period_offset;
                    r_period_offset <= r_period_offset + 40'(r_period);
                    r_zc_count      <= r_zc_count + 5'd1;
                end
                ST_END: begin
                    if (len_ok && (r_zc_count != 5'd0)) begin
                        r_op_mean <= 1'b1;
                    end else if (out_free) begin
                        r_out_data.mean_phase      <= 32'sd0;
                        r_out_data.crossing_count  <= len_ok ? r_zc_count : 5'd0;
                        r_out_data.status          <= len_ok ? STATUS_OK : STATUS_LEN_ERR;
                        r_prev_time                <= '0;
                        r_prev_value               <= '0;
                        r_have_prev                <= 1'b0;
                        r_phase_sum                <= '0;
                        r_period_offset            <= '0;
                        r_zc_count                 <= '0;
                        r_seen                     <= '0;
                    end
                end
                ST_SAT: begin
                    if (out_free) begin
                        r_out_data.mean_phase      <= sat_val;
                        r_out_data.crossing_count  <= r_zc_count;
                        r_out_data.status          <= STATUS_OK;
                        r_prev_time                <= '0;
                        r_prev_value               <= '0;
                        r_have_prev                <= 1'b0;
                        r_phase_sum                <= '0;
                        r_period_offset            <= '0;
                        r_zc_count                 <= '0;
                        r_seen                     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the crossing datapath and the divider.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                // The interpolation operands come from the stored sample and
                // the new one; they only matter when a crossing follows.
                r_x1  <= r_prev_time;
                r_dx  <= 33'(i_in_data.sample_time) - 33'(r_prev_time);
                r_ny1 <= 16'(17'sd0 - 17'(r_prev_value));
                r_den <= 16'(17'(i_in_data.sample_value) - 17'(r_prev_value));
            end
            ST_MUL: begin
                r_prod <= 49'(mul_full);
            end
            ST_LOAD: begin
                r_rem <= '0;
                if (r_op_mean) begin
                    r_quo <= {8'd0, sum_mag};
                    r_dvs <= {11'd0, r_zc_count};
                    r_neg <= r_phase_sum[39];
                end else begin
                    r_quo <= prod_mag;
                    r_dvs <= r_den;
                    r_neg <= r_prod[48];
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? div_diff[15:0] : div_trial[15:0];
                r_quo <= {r_quo[46:0], div_ge};
            end
            ST_FIX: begin
                r_zc_time <= 40'(r_x1) + quo_signed;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- bench/zero_crossing_phase_estimator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zero-crossing phase estimator testbench
// Drives sample blocks into the estimator and checks every result request
// against a cycle-free predictor kept in step with each accepted sample.
// A short table of hand-built blocks comes first. Random blocks follow:
// sine-like, flat, full-scale, wrong length, crossing-saturating and noise.
// They run under four sender/receiver idle mixes and four period settings.
// ----------------------------------------------------------------------------
module zero_crossing_phase_estimator_unit_tb;

    import zcpe_pkg::*;

    localparam int BLOCK_LEN    = 32;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CFG_SETTLE   = 64;    // covers the final mean division
    localparam int END_SETTLE   = 120;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_PRINTED  = 40;

    // Idle mixes, one per phase: none, sender only, receiver only, both.
    localparam int SEND_PCT  [4] = '{0, 66, 0, 20};
    localparam int STALL_PCT [4] = '{0, 0, 66, 20};

    // Shapes of random sample blocks.
    typedef enum int {
        BLK_SINE,
        BLK_FLAT,
        BLK_EXTREME,
        BLK_BAD_LEN,
        BLK_ALT,
        BLK_NOISE
    } t_block_kind;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        t_zcpe_in  smp;
        bit        typed;
        t_zcpe_out want;
    } t_dir_row;

    localparam t_zcpe_out LEN_ERR_RESULT = '{32'sd0, 5'd0, STATUS_LEN_ERR};
    localparam t_zcpe_out NO_RESULT      = '{32'sd0, 5'd0, STATUS_OK};

    // Every directed block is short, so each one closes with a length error.
    localparam t_dir_row DIR_ROWS [13] = '{
        // A lone marked sample right after reset.
        '{'{32'sd0, 16'sd0, 1'b1}, 1'b1, LEN_ERR_RESULT},
        // Full-scale rising crossing across the whole time range.
        '{'{32'h8000_0000, 16'sh8000, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'h7FFF_FFFF, 16'sh7FFF, 1'b1}, 1'b1, LEN_ERR_RESULT},
        // A sample at exactly zero is not a crossing on either side.
        '{'{32'sd6553600, -16'sd1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd6619136, 16'sd0, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd6684672, 16'sd1, 1'b1}, 1'b1, LEN_ERR_RESULT},
        // Time stamps running backwards through a crossing.
        '{'{32'sd500, -16'sd300, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd200, 16'sd40, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd100, -16'sd7, 1'b1}, 1'b1, LEN_ERR_RESULT},
        // Falling edge, then a rising edge just past zero, then a falling mark.
        '{'{-32'sd1, 16'sh7FFF, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd0, 16'sh8000, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd1, 16'sd1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'sd2, -16'sd1, 1'b1}, 1'b1, LEN_ERR_RESULT}
    };

    // DUT ports. Every input holds a known value from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_zcpe_in   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_zcpe_out  o_out_data;

    // Predictor state: the period register and the running block sums.
    logic [30:0]        period_reg;
    logic signed [31:0] last_time;
    logic signed [15:0] last_value;
    bit                 have_last;
    logic [39:0]        sum_acc;
    logic [39:0]        offset_acc;
    logic [4:0]         zc_found;
    logic [5:0]         seen;

    t_zcpe_out   phase_results_q [$];
    bit          typed_pending = 1'b0;
    t_zcpe_out   typed_want    = '0;
    int unsigned send_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned samples_sent  = 0;
    int unsigned random_items  = 0;
    int unsigned cycle_count   = 0;
    logic [30:0] phase_period [4];

    zero_crossing_phase_estimator_unit #(
        .BLOCK_SAMPLES(BLOCK_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Forget the current block; the period register is kept.
    function automatic void clear_block();
        last_time  = '0;
        last_value = '0;
        have_last  = 1'b0;
        sum_acc    = '0;
        offset_acc = '0;
        zc_found   = '0;
        seen       = '0;
    endfunction

    // Advances the block state by one sample. Returns 1 when the sample closes
    // a block, with the mean phase request in res.
    function automatic bit predict_sample(input t_zcpe_in smp, output t_zcpe_out res);
        longint x1, y1, x2, y2, cross_t, adj, mean;
        res = NO_RESULT;
        x2 = $signed(smp.sample_time);
        y2 = $signed(smp.sample_value);
        if (seen != SEEN_MAX) begin
            seen++;
        end
        if (have_last) begin
            x1 = last_time;
            y1 = last_value;
            // Only a strict sign change from below to above zero counts.
            if (y1 < 0 && y2 > 0 && zc_found != ZC_MAX) begin
                // Linear interpolation, quotient truncated toward zero.
                cross_t = x1 + ((-y1) * (x2 - x1)) / (y2 - y1);
                // The n-th crossing, counting from zero, is pulled back by n whole periods.
                adj = cross_t - longint'(offset_acc);
                sum_acc    = sum_acc + adj[39:0];
                offset_acc = offset_acc + 40'(period_reg);
                zc_found++;
            end
        end
        last_time  = smp.sample_time;
        last_value = smp.sample_value;
        have_last  = 1'b1;
        if (!smp.last_sample) begin
            return 1'b0;
        end
        if (seen != BLOCK_LEN) begin
            res = LEN_ERR_RESULT;
        end else begin
            mean = 0;
            if (zc_found != 0) begin
                mean = longint'($signed(sum_acc)) / longint'(zc_found);
                if (mean > 64'sd2147483647) begin
                    mean = 64'sd2147483647;
                end
                if (mean < -64'sd2147483648) begin
                    mean = -64'sd2147483648;
                end
            end
            res.mean_phase     = mean[31:0];
            res.crossing_count = zc_found;
            res.status         = STATUS_OK;
        end
        clear_block();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
        error_count++;
    endtask

    // Everything is sampled at the rising edge, before the DUT's own updates
    // land, so the view here matches what the DUT itself acted on.
    always @(posedge i_clk) begin : score
        t_zcpe_out predicted;
        t_zcpe_out want;
        if (!i_rst_n) begin
            period_reg = '0;
            clear_block();
        end else begin
            if (i_cfg_we) begin
                period_reg = i_cfg_wdata;
            end
            if (i_in_valid && !o_in_stall) begin
                if (predict_sample(i_in_data, predicted)) begin
                    // Table rows with a typed result are held to that value.
                    phase_results_q.push_back(typed_pending ? typed_want : predicted);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (phase_results_q.size() == 0) begin
                    report_error($sformatf("result with none pending: phase %0d count %0d st %0b",
                        o_out_data.mean_phase, o_out_data.crossing_count,
                        o_out_data.status));
                end else begin
                    want = phase_results_q.pop_front();
                    if (o_out_data.mean_phase !== want.mean_phase) begin
                        report_error($sformatf("mean_phase got %0d want %0d",
                            o_out_data.mean_phase, want.mean_phase));
                    end
                    if (o_out_data.crossing_count !== want.crossing_count) begin
                        report_error($sformatf("crossing_count got %0d want %0d",
                            o_out_data.crossing_count, want.crossing_count));
                    end
                    if (o_out_data.status !== want.status) begin
                        report_error($sformatf("status got %0b want %0b",
                            o_out_data.status, want.status));
                    end
                end
            end
        end
    end

    // A hung DUT must still end the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending.",
                cycle_count, phase_results_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // The receiver stalls at random, changing only at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Presents one sample, holding it until accepted. Entered and left at a
    // falling edge; valid drops on exit and the next call may raise it again
    // in the same step, which the rising-edge logic never sees.
    task automatic send_sample(input t_zcpe_in smp, input bit typed, input t_zcpe_out want);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_in_data     = smp;
        typed_pending = typed;
        typed_want    = want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        samples_sent++;
    endtask

    task automatic drain_results();
        while (phase_results_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The period register is only touched once the block has gone quiet.
    task automatic set_period(input logic [30:0] period);
        drain_results();
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_wdata = period;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One random block. Most are well-formed 32-sample blocks whose sign
    // flips in short runs, so each carries several rising crossings.
    task automatic random_block();
        t_block_kind kind;
        int unsigned pick, len, run_max, run, mag;
        int          val;
        bit          positive;
        logic [31:0] t_now, t_step;
        t_zcpe_in    smp;
        pick = $urandom_range(99);
        if (pick < 60) begin
            kind = BLK_SINE;
        end else if (pick < 70) begin
            kind = BLK_FLAT;
        end else if (pick < 80) begin
            kind = BLK_EXTREME;
        end else if (pick < 90) begin
            kind = BLK_BAD_LEN;
        end else if (pick < 95) begin
            kind = BLK_ALT;
        end else begin
            kind = BLK_NOISE;
        end
        len     = BLOCK_LEN;
        run_max = 4;
        t_now   = $urandom_range(1 << 29) - (1 << 28);
        t_step  = $urandom_range(1 << 20, 1 << 10);
        case (kind)
            BLK_FLAT: begin
                run_max = 0;
            end
            BLK_EXTREME: begin
                // Arbitrary stamps: steps wrap and often run backwards.
                t_now  = $urandom;
                t_step = $urandom;
            end
            BLK_BAD_LEN: begin
                len = $urandom_range(1) ? $urandom_range(31, 1) : $urandom_range(62, 33);
            end
            BLK_ALT: begin
                // Over 63 samples with a crossing every other one: both the
                // sample counter and the crossing counter saturate.
                len     = $urandom_range(75, 64);
                run_max = 1;
            end
            BLK_NOISE: begin
                len = $urandom_range(80, 1);
            end
            default: begin
            end
        endcase
        positive = $urandom_range(1);
        run      = (run_max == 0) ? len + 1 : 0;
        for (int i = 0; i < len; i++) begin
            if (run == 0) begin
                positive = !positive;
                run      = $urandom_range(run_max, 1);
            end
            run--;
            mag = ($urandom_range(15) == 0) ? 0 : $urandom_range(32767, 1);
            if (kind == BLK_EXTREME) begin
                mag = $urandom_range(1) ? (positive ? 32767 : 32768) : 1;
            end
            val = positive ? int'(mag) : -int'(mag);
            smp.sample_time  = t_now;
            smp.sample_value = 16'(val);
            smp.last_sample  = (i == len - 1);
            if (kind == BLK_NOISE) begin
                smp.sample_time  = $urandom;
                smp.sample_value = 16'($urandom);
                smp.last_sample  = ($urandom_range(15) == 0) || (i == len - 1);
            end
            send_sample(smp, 1'b0, NO_RESULT);
            random_items++;
            if (smp.last_sample) begin
                break;
            end
            t_now = t_now + t_step + $urandom_range(255) - 128;
        end
    endtask

    initial begin
        int unsigned blocks;
        phase_period[0] = 31'd0;
        phase_period[1] = 31'h7FFF_FFFF;
        phase_period[2] = 31'($urandom_range(1 << 26, 1 << 12));
        phase_period[3] = 31'($urandom);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table, run with the period still at its reset value.
        foreach (DIR_ROWS[k]) begin
            send_sample(DIR_ROWS[k].smp, DIR_ROWS[k].typed, DIR_ROWS[k].want);
        end

        // Random blocks in four phases, each with its own period and idle mix.
        for (int ph = 0; ph < 4; ph++) begin
            set_period(phase_period[ph]);
            send_pct  = SEND_PCT[ph];
            stall_pct = STALL_PCT[ph];
            blocks    = 0;
            while (random_items < (ph + 1) * RANDOM_ITEMS / 4) begin
                random_block();
                blocks++;
                // Once per phase the sender holds off until the DUT is empty.
                if (blocks == 3) begin
                    drain_results();
                end
            end
        end

        drain_results();
        send_pct  = 0;
        stall_pct = 0;
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Sent %0d samples (%0d in random blocks); %0d block results compared.",
            samples_sent, random_items, results_seen);
        $display("Periods of zero, full scale and two random values; %0d mismatches logged.",
            error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- zero_crossing_phase_estimator_unit.f -----
src/zcpe_pkg.sv
src/zero_crossing_phase_estimator_unit.sv
bench/zero_crossing_phase_estimator_unit_tb.sv
